### hdl/ase_pkg.sv
`timescale 1ns / 1ps

package ase_pkg;

  localparam int unsigned PairsWidth = 10;
  localparam int unsigned DenomWidth = 12;
  localparam int unsigned PcWidth    = 4;

  localparam logic [PairsWidth-1:0] TermPairsReset = 10'd32;

  // Step addresses of the microprogram
  localparam logic [PcWidth-1:0] PC_IDLE  = 4'd0;
  localparam logic [PcWidth-1:0] PC_TEST  = 4'd1;
  localparam logic [PcWidth-1:0] PC_MUL0  = 4'd2;
  localparam logic [PcWidth-1:0] PC_MUL1  = 4'd3;
  localparam logic [PcWidth-1:0] PC_DIVS  = 4'd4;
  localparam logic [PcWidth-1:0] PC_MUL2  = 4'd5;
  localparam logic [PcWidth-1:0] PC_MUL3  = 4'd6;
  localparam logic [PcWidth-1:0] PC_DIVA  = 4'd7;
  localparam logic [PcWidth-1:0] PC_EMIT  = 4'd8;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_TEST,
    OP_MUL,
    OP_DIV,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DONE
  } cond_e;

  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic               sub;
    logic               bump_k;
    logic [PcWidth-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ctrl_word(input logic [PcWidth-1:0] pc);
    ctrl_t cw;
    cw = '{op: OP_IDLE, cond: COND_NEXT, sub: 1'b0, bump_k: 1'b0, target: PC_IDLE};
    unique case (pc)
      PC_IDLE: cw = '{op: OP_IDLE, cond: COND_NEXT,   sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
      PC_TEST: cw = '{op: OP_TEST, cond: COND_DONE,   sub: 1'b0, bump_k: 1'b0,
                      target: PC_EMIT};
      PC_MUL0: cw = '{op: OP_MUL,  cond: COND_NEXT,   sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
      PC_MUL1: cw = '{op: OP_MUL,  cond: COND_NEXT,   sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
      PC_DIVS: cw = '{op: OP_DIV,  cond: COND_NEXT,   sub: 1'b1, bump_k: 1'b0,
                      target: PC_IDLE};
      PC_MUL2: cw = '{op: OP_MUL,  cond: COND_NEXT,   sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
      PC_MUL3: cw = '{op: OP_MUL,  cond: COND_NEXT,   sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
      PC_DIVA: cw = '{op: OP_DIV,  cond: COND_ALWAYS, sub: 1'b0, bump_k: 1'b1,
                      target: PC_TEST};
      PC_EMIT: cw = '{op: OP_EMIT, cond: COND_ALWAYS, sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
      default: cw = '{op: OP_IDLE, cond: COND_ALWAYS, sub: 1'b0, bump_k: 1'b0,
                      target: PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

### hdl/arctan_series_evaluator_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                       | Payload
// ---------+-----+---------------------------------+---------------------------------------
// s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata[31:0] = x_value (Q2.30)
// m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata[31:0] = arctan_value, tuser[0] =
//          |     |                                 | range_error
// cfg      | in  | cfg_we_i                        | cfg_wdata_i[9:0] = term_pairs
//
// Each of the term_pairs pairs runs four shift-add multiplies and two restoring
// divides on one bit per cycle, stepped by a microprogram.
// Reset clears the sequencer and loads term_pairs with 32.
// The result waits in an output register; the next x is taken meanwhile, and
// the emit step holds only if that register is still full.

module arctan_series_evaluator_top #(
  parameter int unsigned FRACTION_BITS = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] x_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] arctan_value
  output logic [0:0]  m_axis_tuser_o,   // [0] range_error
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i
);

  localparam int unsigned W  = FRACTION_BITS + 1;
  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned PW = ase_pkg::PairsWidth;
  localparam int unsigned DW = ase_pkg::DenomWidth;

  ase_pkg::ctrl_t cw;

  logic [ase_pkg::PcWidth-1:0] pc_q, pc_d;
  logic                        busy_q, busy_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [PW-1:0]               k_q, k_d;
  logic [PW-1:0]               term_pairs_q, term_pairs_d;
  logic [DW-1:0]               denom_q, denom_d;
  logic                        out_valid_q, out_valid_d;

  logic          neg_q, neg_d;
  logic          flag_q, flag_d;
  logic [W-1:0]  ax_q, ax_d;
  logic [W-1:0]  p_q, p_d;
  logic [W-1:0]  sum_q, sum_d;
  logic [W:0]    acc_q, acc_d;
  logic [W-1:0]  sh_q, sh_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [31:0]   out_data_q, out_data_d;
  logic          out_flag_q, out_flag_d;

  logic signed [31:0] x_s;
  logic [31:0]        x_neg;
  logic               over_hi, over_lo;
  logic [30:0]        mag;
  logic [W+30:0]      ax_ext;
  logic [W+30:0]      res_ext;
  logic [30:0]        res_mag;
  logic [W:0]         acc_sum;
  logic [DW:0]        trial;
  logic               qbit;
  logic               step_done;
  logic               take_jump;

  assign cw = ase_pkg::ctrl_word(pc_q);

  assign x_s     = s_axis_tdata_i;
  assign x_neg   = 32'(-x_s);
  assign over_hi = x_s > 32'sh4000_0000;
  assign over_lo = x_s < -32'sh4000_0000;
  assign mag     = (over_hi || over_lo) ? 31'h4000_0000
                 : (x_s[31] ? x_neg[30:0] : s_axis_tdata_i[30:0]);
  // Q2.30 magnitude scaled to FRACTION_BITS: mag * 2^W >> 31
  assign ax_ext  = {mag, {W{1'b0}}};

  // Internal sum scaled back to 30 fraction bits: sum * 2^31 >> W
  assign res_ext = {sum_q, 31'b0};
  assign res_mag = res_ext[W+30:W];

  assign acc_sum = acc_q + (sh_q[0] ? {1'b0, ax_q} : '0);
  assign trial   = {rem_q, sh_q[W-1]};
  assign qbit    = trial >= {1'b0, denom_q};

  assign s_axis_tready_o = cw.op == ase_pkg::OP_IDLE;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_flag_q;

  always_comb begin
    pc_d         = pc_q;
    busy_d       = busy_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    term_pairs_d = term_pairs_q;
    denom_d      = denom_q;
    out_valid_d  = out_valid_q;
    neg_d        = neg_q;
    flag_d       = flag_q;
    ax_d         = ax_q;
    p_d          = p_q;
    sum_d        = sum_q;
    acc_d        = acc_q;
    sh_d         = sh_q;
    rem_d        = rem_q;
    out_data_d   = out_data_q;
    out_flag_d   = out_flag_q;
    step_done    = 1'b0;

    if (cfg_we_i) begin
      term_pairs_d = cfg_wdata_i;
    end

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (cw.op)
      ase_pkg::OP_IDLE: begin
        if (s_axis_tvalid_i) begin
          neg_d     = x_s[31];
          flag_d    = over_hi || over_lo;
          ax_d      = ax_ext[W+30:31];
          p_d       = ax_ext[W+30:31];
          sum_d     = ax_ext[W+30:31];
          denom_d   = DW'(1);
          k_d       = '0;
          step_done = 1'b1;
        end
      end
      ase_pkg::OP_TEST: begin
        step_done = 1'b1;
      end
      ase_pkg::OP_MUL: begin
        if (!busy_q) begin
          busy_d = 1'b1;
          cnt_d  = '0;
          acc_d  = '0;
          sh_d   = p_q;
        end else if (cnt_q != CW'(FRACTION_BITS)) begin
          // low fraction bits of p: add, shift right
          acc_d = acc_sum >> 1;
          sh_d  = sh_q >> 1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          // top bit of p carries weight one
          p_d       = acc_sum[W-1:0];
          busy_d    = 1'b0;
          step_done = 1'b1;
        end
      end
      ase_pkg::OP_DIV: begin
        if (!busy_q) begin
          busy_d  = 1'b1;
          cnt_d   = '0;
          rem_d   = '0;
          sh_d    = p_q;
          denom_d = denom_q + DW'(2);
        end else if (cnt_q != CW'(W)) begin
          rem_d = qbit ? DW'(trial - {1'b0, denom_q}) : trial[DW-1:0];
          sh_d  = {sh_q[W-2:0], qbit};
          cnt_d = cnt_q + 1'b1;
        end else begin
          sum_d     = cw.sub ? sum_q - sh_q : sum_q + sh_q;
          k_d       = cw.bump_k ? k_q + 1'b1 : k_q;
          busy_d    = 1'b0;
          step_done = 1'b1;
        end
      end
      ase_pkg::OP_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = neg_q ? 32'(-{1'b0, res_mag}) : {1'b0, res_mag};
          out_flag_d  = flag_q;
          step_done   = 1'b1;
        end
      end
      default: begin
        step_done = 1'b1;
      end
    endcase

    take_jump = (cw.cond == ase_pkg::COND_ALWAYS)
             || (cw.cond == ase_pkg::COND_DONE && k_q == term_pairs_q);
    if (step_done) begin
      pc_d = take_jump ? cw.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= ase_pkg::PC_IDLE;
      busy_q       <= 1'b0;
      cnt_q        <= '0;
      k_q          <= '0;
      term_pairs_q <= ase_pkg::TermPairsReset;
      denom_q      <= DW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      busy_q       <= busy_d;
      cnt_q        <= cnt_d;
      k_q          <= k_d;
      term_pairs_q <= term_pairs_d;
      denom_q      <= denom_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    flag_q     <= flag_d;
    ax_q       <= ax_d;
    p_q        <= p_d;
    sum_q      <= sum_d;
    acc_q      <= acc_d;
    sh_q       <= sh_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
    out_flag_q <= out_flag_d;
  end

  a_denom_odd: assert property (@(posedge clk_i) disable iff (!rst_ni) denom_q[0])
    else $error("denominator lost its odd value");

  a_busy_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cw.op == ase_pkg::OP_MUL || cw.op == ase_pkg::OP_DIV))
    else $error("serial unit busy outside a multiply or divide step");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(W))
    else $error("bit counter past word width");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == ase_pkg::OP_EMIT && step_done) |=> m_axis_tvalid_o)
    else $error("emit step did not raise result valid");

endmodule

### verif/arctan_series_evaluator_top_tb.sv
`timescale 1ns / 1ps

module arctan_series_evaluator_top_tb;

  localparam int unsigned FracBits      = 30;
  localparam longint      IoOne         = 64'sd1073741824;
  localparam int          ResetCycles   = 6;
  localparam int          HoldCycles    = 3000;
  localparam int          EndSlack      = 200;
  localparam int          WatchdogLimit = 1000000;
  localparam int          MaxReports    = 10;

  // receiver behavior outside a hold-off
  localparam int RxAlways = 0;
  localparam int RxRuns   = 1;
  localparam int RxCoin   = 2;

  typedef struct packed {
    logic [31:0] value;
    logic        range_error;
  } arctan_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;

  arctan_result_t                 arctan_expected[$];
  logic [ase_pkg::PairsWidth-1:0] term_pairs_model = ase_pkg::TermPairsReset;

  int  fail_count = 0;
  int  reported = 0;
  int  x_accepted = 0;
  int  results_seen = 0;
  int  clamp_count = 0;
  int  idle_cycles = 0;
  int  rx_mode = RxAlways;
  bit  hold_request = 1'b0;

  arctan_series_evaluator_top #(
    .FRACTION_BITS(FracBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // (a * b) >> FracBits on the full product, truncating
  function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[FracBits +: 64];
  endfunction

  function automatic arctan_result_t predict_arctan(input logic [31:0] x_raw,
                                                    input logic [9:0]  pairs);
    arctan_result_t r;
    longint      x;
    logic        neg;
    logic [63:0] mag, ax, pw, sum, d, res_mag;
    x = {{32{x_raw[31]}}, x_raw};
    r.range_error = 1'b0;
    if (x > IoOne) begin
      x = IoOne;
      r.range_error = 1'b1;
    end
    if (x < -IoOne) begin
      x = -IoOne;
      r.range_error = 1'b1;
    end
    neg = x < 0;
    mag = neg ? -x : x;
    if (FracBits >= 30) ax = mag << (FracBits - 30);
    else ax = mag >> (30 - FracBits);
    pw  = ax;
    sum = ax;
    d   = 64'd1;
    for (int k = 0; k < pairs; k++) begin
      pw  = fixed_mul(fixed_mul(pw, ax), ax);
      d   = d + 64'd2;
      sum = sum - pw / d;
      pw  = fixed_mul(fixed_mul(pw, ax), ax);
      d   = d + 64'd2;
      sum = sum + pw / d;
    end
    if (FracBits >= 30) res_mag = sum >> (FracBits - 30);
    else res_mag = sum << (30 - FracBits);
    r.value = neg ? -res_mag[31:0] : res_mag[31:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (reported < MaxReports) begin
      reported++;
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Check results first, then record the new transfer on the input side
  always @(posedge clk_i) begin
    arctan_result_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (arctan_expected.size() == 0) begin
        note_mismatch("unexpected result", 32'hx, m_axis_tdata_o);
      end else begin
        want = arctan_expected.pop_front();
        if (m_axis_tdata_o !== want.value)
          note_mismatch("arctan_value", want.value, m_axis_tdata_o);
        if (m_axis_tuser_o[0] !== want.range_error)
          note_mismatch("range_error", {31'd0, want.range_error}, {31'd0, m_axis_tuser_o[0]});
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      want = predict_arctan(s_axis_tdata_i, term_pairs_model);
      arctan_expected.push_back(want);
      x_accepted++;
      if (want.range_error) clamp_count++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               WatchdogLimit, arctan_expected.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int countdown;
    bit run_ready;
    countdown = 0;
    run_ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
        countdown = 0;
      end else begin
        case (rx_mode)
          RxRuns: begin
            if (countdown == 0) begin
              run_ready = ~run_ready;
              countdown = run_ready ? $urandom_range(1, 50) : $urandom_range(1, 600);
            end else begin
              countdown--;
            end
            m_axis_tready_i <= run_ready;
          end
          RxCoin:  m_axis_tready_i <= $urandom_range(0, 1);
          default: m_axis_tready_i <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_x(input logic [31:0] x);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= x;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_until_idle();
    pause_sender(1);
    while (arctan_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_term_pairs(input logic [9:0] pairs);
    wait_until_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pairs;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    term_pairs_model = pairs;
  endtask

  function automatic logic [31:0] random_x();
    logic [31:0] x;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: x = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
      6, 7: x = $urandom;
      8: begin
        x = 32'h4000_0000 + $urandom_range(0, 3) - 32'd2;
        if ($urandom_range(0, 1)) x = -x;
      end
      default: begin
        x = $urandom_range(0, 1023);
        if ($urandom_range(0, 1)) x = -x;
      end
    endcase
    return x;
  endfunction

  // Reset value of term_pairs, no write yet
  task automatic test_reset_pairs();
    logic [31:0] xs[11];
    xs = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001, 32'hBFFF_FFFF,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h2000_0000,
           32'hE000_0000};
    rx_mode = RxAlways;
    foreach (xs[i]) send_x(xs[i]);
    wait_until_idle();
  endtask

  // No pairs summed: result is the clamped argument
  task automatic test_zero_pairs();
    write_term_pairs(10'd0);
    send_x(32'h2000_0000);
    send_x(32'hBFFF_FFFB);
    send_x(32'h7FFF_FFFF);
    send_x(32'h0000_3039);
    wait_until_idle();
  endtask

  task automatic test_max_pairs();
    write_term_pairs(10'd1023);
    send_x(32'h8000_0000);
    wait_until_idle();
  endtask

  task automatic test_min_pairs();
    write_term_pairs(10'd1);
    rx_mode = RxCoin;
    send_x(32'h4000_0000);
    send_x(32'hC000_0000);
    send_x(32'h4000_0001);
    send_x(32'h0CCC_CCCD);
    wait_until_idle();
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    write_term_pairs(10'd1);
    rx_mode = RxAlways;
    hold_request = 1'b1;
    repeat (12) send_x(random_x());
    while (hold_request) @(negedge clk_i);
    wait_until_idle();
  endtask

  task automatic test_random_sweep();
    int gap_limit[6];
    int gap;
    int sent;
    int burst;
    gap_limit = '{0, 40, 400, 5, 200, 1000};
    for (int ph = 0; ph < 6; ph++) begin
      write_term_pairs((ph == 0) ? 10'd2 : 10'($urandom_range(1, 8)));
      rx_mode = ph % 3;
      sent = 0;
      while (sent < 40) begin
        burst = $urandom_range(1, 6);
        for (int b = 0; b < burst && sent < 40; b++) begin
          send_x(random_x());
          sent++;
        end
        if (gap_limit[ph] > 0 && $urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, gap_limit[ph]);
          pause_sender(gap);
        end
      end
    end
    wait_until_idle();
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_pairs();
    test_zero_pairs();
    test_max_pairs();
    test_min_pairs();
    test_output_hold_off();
    test_random_sweep();

    wait_until_idle();
    repeat (EndSlack) @(posedge clk_i);
    if (arctan_expected.size() != 0) begin
      $display("%0d expected results never arrived", arctan_expected.size());
      fail_count += arctan_expected.size();
    end
    $display("Run: %0d arguments (%0d clamped), %0d results, %0d failures",
             x_accepted, clamp_count, results_seen, fail_count);
    $display("term_pairs covered reset value, 0, 1, 1023 and random 1..8, with hold-off");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
